### sv/tws_pkg.sv
// Package for the three-wire serial master: pin phase codes, state and
// transaction types, and the packed BCD to binary conversion.
// No dependencies.
`timescale 1ns / 1ps

package tws_pkg;

    localparam int PHASE_W = 4;

    // Pin phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_EN_LOW  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_EN_HIGH = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ADDR_LO = 4'd3;
    localparam logic [PHASE_W-1:0] PH_ADDR_HI = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_LO   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_HI   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RD_LO   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_HI   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_END_EN  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_END_CLO = 4'd10;
    localparam logic [PHASE_W-1:0] PH_END_CHI = 4'd11;
    localparam logic [PHASE_W-1:0] PH_END_D0  = 4'd12;
    localparam logic [PHASE_W-1:0] PH_END_D1  = 4'd13;

    localparam logic [2:0] LAST_BIT = 3'd7;

    // Register addresses
    localparam logic REG_BCD = 1'b0;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [2:0]         bit_count;
        logic [7:0]         shift_out;
        logic [7:0]         shift_in;
        logic [7:0]         data_latch;
        logic               is_read;
    } t_state;

    typedef struct packed {
        logic       start_req;
        logic       func;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       data_pin_in;
    } t_item;

    typedef struct packed {
        logic       enable_pin;
        logic       clock_pin;
        logic       data_pin_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } t_result;

    // Packed BCD to binary: high nibble times ten plus low nibble
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0000, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
    endfunction

endpackage

### sv/tws_step.sv
// Next-state and pin logic for one tick of the three-wire serial master.
// Depends on tws_pkg.
`timescale 1ns / 1ps

module tws_step
    import tws_pkg::*;
(
    input  t_state  i_cur,
    input  t_item   i_item,
    input  logic    i_bcd,
    output t_state  o_nxt,
    output t_result o_res
);

    t_state s;

    // Latch operands on a start request while idle
    always_comb begin
        s = i_cur;
        if (i_cur.phase == PH_IDLE || i_cur.phase > PH_END_D1) begin
            if (i_item.start_req) begin
                s.is_read    = i_item.func;
                s.shift_out  = i_item.address;
                s.data_latch = i_item.write_data;
                s.shift_in   = 8'h00;
                s.bit_count  = 3'd0;
                s.phase      = PH_EN_LOW;
            end else begin
                s.phase = PH_IDLE;
            end
        end
    end

    // Drive pins for the current phase and pick the next one
    always_comb begin
        o_nxt       = s;
        o_nxt.phase = PH_IDLE;
        o_res       = '0;
        o_res.busy_res = 1'b1;
        case (s.phase)
            PH_EN_LOW: begin
                o_nxt.phase = PH_EN_HIGH;
            end
            PH_EN_HIGH: begin
                o_res.enable_pin = 1'b1;
                o_nxt.phase      = PH_ADDR_LO;
            end
            PH_ADDR_LO, PH_WR_LO: begin
                o_res.enable_pin   = 1'b1;
                o_res.data_drive   = 1'b1;
                o_res.data_pin_out = s.shift_out[0];
                o_nxt.phase        = s.phase + 4'd1;
            end
            PH_ADDR_HI, PH_WR_HI: begin
                o_res.enable_pin   = 1'b1;
                o_res.clock_pin    = 1'b1;
                o_res.data_drive   = 1'b1;
                o_res.data_pin_out = s.shift_out[0];
                o_nxt.shift_out    = s.shift_out >> 1;
                if (s.bit_count == LAST_BIT) begin
                    o_nxt.bit_count = 3'd0;
                    if (s.phase == PH_WR_HI) begin
                        o_nxt.phase = PH_END_EN;
                    end else if (s.is_read) begin
                        o_nxt.phase = PH_RD_LO;
                    end else begin
                        o_nxt.shift_out = s.data_latch;
                        o_nxt.phase     = PH_WR_LO;
                    end
                end else begin
                    o_nxt.bit_count = s.bit_count + 3'd1;
                    o_nxt.phase     = s.phase - 4'd1;
                end
            end
            PH_RD_LO: begin
                o_res.enable_pin = 1'b1;
                o_nxt.shift_in   = {i_item.data_pin_in, s.shift_in[7:1]};
                o_nxt.phase      = PH_RD_HI;
            end
            PH_RD_HI: begin
                o_res.enable_pin = 1'b1;
                o_res.clock_pin  = 1'b1;
                if (s.bit_count == LAST_BIT) begin
                    o_nxt.bit_count = 3'd0;
                    o_nxt.phase     = PH_END_EN;
                end else begin
                    o_nxt.bit_count = s.bit_count + 3'd1;
                    o_nxt.phase     = PH_RD_LO;
                end
            end
            PH_END_EN: begin
                o_res.clock_pin = 1'b1;
                if (s.is_read) begin
                    o_nxt.phase = PH_END_CLO;
                end else begin
                    o_res.done_res = 1'b1;
                end
            end
            PH_END_CLO: begin
                o_nxt.phase = PH_END_CHI;
            end
            PH_END_CHI: begin
                o_res.clock_pin = 1'b1;
                o_nxt.phase     = PH_END_D0;
            end
            PH_END_D0: begin
                o_res.clock_pin  = 1'b1;
                o_res.data_drive = 1'b1;
                o_nxt.phase      = PH_END_D1;
            end
            PH_END_D1: begin
                o_res.clock_pin    = 1'b1;
                o_res.data_drive   = 1'b1;
                o_res.data_pin_out = 1'b1;
                o_res.done_res     = 1'b1;
                o_res.read_byte    = i_bcd ? bcd_to_bin(s.shift_in) : s.shift_in;
            end
            default: begin
                o_res.busy_res = 1'b0;
            end
        endcase
    end

endmodule

### sv/three_wire_serial_master.sv
// Three-wire serial master: each tick drives one pin phase of the bus.
// A tick's pin levels pass through the input register, then the result register, before
// they appear on the outputs. Throughput: one tick per cycle while the receiver does not stall;
// the step logic between the two registers is a single pass.
// Reset (synchronous, active low) empties both registers, returns the bus to
// idle and clears the BCD conversion enable.
`timescale 1ns / 1ps

module three_wire_serial_master
    import tws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_req,
    input  logic        i_func,
    input  logic [7:0]  i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_data_pin_in,
    // pin level channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_enable_pin,
    output logic        o_clock_pin,
    output logic        o_data_pin_out,
    output logic        o_data_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    logic    r_bcd;
    logic    consume;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BCD) ? {31'd0, r_bcd} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_BCD) begin
            r_bcd <= pwdata[0];
        end
    end

    // Step a tick when the result register is free or being drained
    assign consume    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || consume;

    tws_step u_step (
        .i_cur  (r_state),
        .i_item (r_item),
        .i_bcd  (r_bcd),
        .o_nxt  (n_state),
        .o_res  (n_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{start_req: i_start_req, func: i_func, address: i_address,
                        write_data: i_write_data, data_pin_in: i_data_pin_in};
        end
    end

    // Bus state advances once per stepped tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_enable_pin   = r_res.enable_pin;
    assign o_clock_pin    = r_res.clock_pin;
    assign o_data_pin_out = r_res.data_pin_out;
    assign o_data_drive   = r_res.data_drive;
    assign o_busy_res     = r_res.busy_res;
    assign o_done_res     = r_res.done_res;
    assign o_read_byte    = r_res.read_byte;

    // Checks
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_rbyte_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_read_byte == 8'h00)
        else $error("read byte outside done tick");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= PH_END_D1)
        else $error("phase code out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && n_res.done_res |=> r_state.phase == PH_IDLE)
        else $error("bus not idle after done");

    a_release_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_data_drive |-> !o_data_pin_out)
        else $error("data level while released");

endmodule

### test/three_wire_serial_master_test.sv
`timescale 1ns / 1ps
// Testbench for three_wire_serial_master: sends ticks over the valid/ready channel,
// predicts the pin levels of every tick and checks each result in order.
// Depends on tws_pkg and the three_wire_serial_master RTL.

module three_wire_serial_master_test;
    import tws_pkg::*;

    localparam logic [2:0] BCD_REG_ADDR = {REG_BCD, 2'b00};
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 8;

    // Pin levels that can be read off at a glance
    localparam t_result IDLE_PINS  = '0;
    localparam t_result START_PINS = {1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00};
    localparam t_result EN_PINS    = {1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00};

    typedef struct packed {
        t_item   tick;
        logic    typed;
        t_result want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_start_req = 1'b0;
    logic        i_func = 1'b0;
    logic [7:0]  i_address = 8'h00;
    logic [7:0]  i_write_data = 8'h00;
    logic        i_data_pin_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_enable_pin;
    logic        o_clock_pin;
    logic        o_data_pin_out;
    logic        o_data_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted bus state and register copy
    logic [PHASE_W-1:0] cur_phase = PH_IDLE;
    logic [2:0]         bits_done = 3'd0;
    logic [7:0]         tx_shift = 8'h00;
    logic [7:0]         rx_shift = 8'h00;
    logic [7:0]         wr_byte = 8'h00;
    logic               reading = 1'b0;
    logic               bcd_en = 1'b0;

    t_result  pin_queue[$];
    t_dir_row dir_tab[$];
    logic [7:0] rd_pattern = 8'h00;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int checked = 0;
    int ticks_total = 0;
    int writes_done = 0;
    int reads_done = 0;
    int bcd_reads = 0;

    three_wire_serial_master dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_req    (i_start_req),
        .i_func         (i_func),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_data_pin_in  (i_data_pin_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_enable_pin   (o_enable_pin),
        .o_clock_pin    (o_clock_pin),
        .o_data_pin_out (o_data_pin_out),
        .o_data_drive   (o_data_drive),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_read_byte    (o_read_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // Advance the bus by one tick and return the pin levels it drives
    function automatic t_result step_bus(input t_item t);
        t_result            r;
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] nxt;
        r = '0;
        r.busy_res = 1'b1;
        nxt = PH_IDLE;
        ph = cur_phase;
        if (ph == PH_IDLE || ph > PH_END_D1) begin
            if (t.start_req) begin
                reading = t.func;
                tx_shift = t.address;
                wr_byte = t.write_data;
                rx_shift = 8'h00;
                bits_done = 3'd0;
                ph = PH_EN_LOW;
            end else begin
                ph = PH_IDLE;
            end
        end
        case (ph)
            PH_EN_LOW: begin
                nxt = PH_EN_HIGH;
            end
            PH_EN_HIGH: begin
                r.enable_pin = 1'b1;
                nxt = PH_ADDR_LO;
            end
            PH_ADDR_LO, PH_WR_LO: begin
                r.enable_pin = 1'b1;
                r.data_drive = 1'b1;
                r.data_pin_out = tx_shift[0];
                nxt = ph + 1'b1;
            end
            PH_ADDR_HI, PH_WR_HI: begin
                r.enable_pin = 1'b1;
                r.clock_pin = 1'b1;
                r.data_drive = 1'b1;
                r.data_pin_out = tx_shift[0];
                tx_shift = tx_shift >> 1;
                if (bits_done == LAST_BIT) begin
                    bits_done = 3'd0;
                    if (ph == PH_WR_HI) begin
                        nxt = PH_END_EN;
                    end else if (reading) begin
                        nxt = PH_RD_LO;
                    end else begin
                        tx_shift = wr_byte;
                        nxt = PH_WR_LO;
                    end
                end else begin
                    bits_done = bits_done + 1'b1;
                    nxt = ph - 1'b1;
                end
            end
            PH_RD_LO: begin
                // Sample shifts in at the top bit
                r.enable_pin = 1'b1;
                rx_shift = {t.data_pin_in, rx_shift[7:1]};
                nxt = PH_RD_HI;
            end
            PH_RD_HI: begin
                r.enable_pin = 1'b1;
                r.clock_pin = 1'b1;
                if (bits_done == LAST_BIT) begin
                    bits_done = 3'd0;
                    nxt = PH_END_EN;
                end else begin
                    bits_done = bits_done + 1'b1;
                    nxt = PH_RD_LO;
                end
            end
            PH_END_EN: begin
                r.clock_pin = 1'b1;
                if (reading) begin
                    nxt = PH_END_CLO;
                end else begin
                    r.done_res = 1'b1;
                end
            end
            PH_END_CLO: begin
                nxt = PH_END_CHI;
            end
            PH_END_CHI: begin
                r.clock_pin = 1'b1;
                nxt = PH_END_D0;
            end
            PH_END_D0: begin
                r.clock_pin = 1'b1;
                r.data_drive = 1'b1;
                nxt = PH_END_D1;
            end
            PH_END_D1: begin
                r.clock_pin = 1'b1;
                r.data_drive = 1'b1;
                r.data_pin_out = 1'b1;
                r.done_res = 1'b1;
                r.read_byte = bcd_en ? 8'(rx_shift[7:4]) * 8'd10 + 8'(rx_shift[3:0])
                                     : rx_shift;
            end
            default: begin
                r.busy_res = 1'b0;
            end
        endcase
        cur_phase = nxt;
        return r;
    endfunction

    // Offer one tick, wait for it to be accepted, then record its expected pins
    task automatic send_tick(input t_item t, input logic typed, input t_result want);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_start_req = t.start_req;
        i_func = t.func;
        i_address = t.address;
        i_write_data = t.write_data;
        i_data_pin_in = t.data_pin_in;
        do @(posedge i_clk); while (!o_in_ready);
        r = step_bus(t);
        pin_queue.push_back(typed ? want : r);
        ticks_total++;
        if (r.done_res) begin
            if (reading) begin
                reads_done++;
                if (bcd_en) bcd_reads++;
            end else begin
                writes_done++;
            end
        end
    endtask

    // Random ticks: mostly whole transactions with random content, some noise
    task automatic run_ticks(input int n);
        t_item t;
        int    busy_ticks;
        busy_ticks = 0;
        while (busy_ticks < n || cur_phase != PH_IDLE) begin
            t.func = 1'($urandom_range(1));
            t.address = 8'($urandom);
            t.write_data = 8'($urandom);
            t.data_pin_in = 1'($urandom_range(1));
            if (cur_phase == PH_IDLE) begin
                t.start_req = ($urandom_range(99) < 75);
                if (t.start_req) begin
                    // Half the read bytes are valid packed BCD
                    rd_pattern = $urandom_range(1) ?
                        {4'($urandom_range(9)), 4'($urandom_range(9))} : 8'($urandom);
                end
            end else begin
                // A start in mid-transaction must be ignored
                t.start_req = ($urandom_range(9) == 0);
                if (cur_phase == PH_RD_LO) t.data_pin_in = rd_pattern[bits_done];
            end
            if (cur_phase != PH_IDLE || t.start_req) busy_ticks++;
            send_tick(t, 1'b0, IDLE_PINS);
        end
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pin_queue.size() != 0) @(posedge i_clk);
    endtask

    // Start a read and stop a few ticks in, leaving the transaction open
    task automatic start_mid();
        t_item t;
        rd_pattern = 8'($urandom);
        t.start_req = 1'b1;
        t.func = 1'b1;
        t.address = 8'($urandom);
        t.write_data = 8'($urandom);
        t.data_pin_in = 1'b0;
        send_tick(t, 1'b0, IDLE_PINS);
        t.start_req = 1'b0;
        repeat (5) send_tick(t, 1'b0, IDLE_PINS);
    endtask

    // Optionally write the conversion enable, then read it back
    task automatic bcd_reg(input logic do_write, input logic value);
        if (do_write) begin
            @(negedge i_clk);
            psel = 1'b1;
            penable = 1'b0;
            pwrite = 1'b1;
            paddr = BCD_REG_ADDR;
            pwdata = {31'd0, value};
            @(negedge i_clk);
            penable = 1'b1;
            do @(posedge i_clk); while (!pready);
            bcd_en = value;
        end
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = BCD_REG_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, bcd_en}) begin
            errors++;
            $display("%0t: bcd_to_binary readback expected %h, got %h",
                     $time, {31'd0, bcd_en}, prdata);
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, got_v);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : watch_pins
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_enable_pin, o_clock_pin, o_data_pin_out, o_data_drive,
                   o_busy_res, o_done_res, o_read_byte};
            if (pin_queue.size() == 0) begin
                errors++;
                $display("%0t: result %h with nothing expected", $time, got);
            end else begin
                want = pin_queue.pop_front();
                checked++;
                check_field("enable_pin", 8'(want.enable_pin), 8'(got.enable_pin));
                check_field("clock_pin", 8'(want.clock_pin), 8'(got.clock_pin));
                check_field("data_pin_out", 8'(want.data_pin_out), 8'(got.data_pin_out));
                check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("read_byte", want.read_byte, got.read_byte);
            end
        end
    end

    // Hard limit on run length
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        // Directed ticks: start, func, address, write_data, data_pin_in
        dir_tab.push_back({{1'b0, 1'b1, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_PINS});
        dir_tab.push_back({{1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_PINS});
        dir_tab.push_back({{1'b1, 1'b0, 8'hA5, 8'h3C, 1'b0}, 1'b1, START_PINS});
        dir_tab.push_back({{1'b1, 1'b1, 8'h00, 8'hFF, 1'b1}, 1'b1, EN_PINS});
        dir_tab.push_back({{1'b0, 1'b1, 8'hFF, 8'h00, 1'b1}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b1, 1'b0, 8'h5A, 8'hC3, 1'b0}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b0, 1'b1, 8'h00, 8'hFF, 1'b1}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b1, 1'b1, 8'h81, 8'h7E, 1'b1}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b0, 1'b0, 8'h7E, 8'h81, 1'b0}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b0, 1'b1, 8'hAA, 8'h55, 1'b1}, 1'b0, IDLE_PINS});
        dir_tab.push_back({{1'b1, 1'b0, 8'h55, 8'hAA, 1'b0}, 1'b0, IDLE_PINS});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset value of the conversion enable
        bcd_reg(1'b0, 1'b0);

        // Directed table, then random ticks with the sender idling lightly
        send_idle_pct = 19;
        recv_idle_pct = 52;
        foreach (dir_tab[k]) send_tick(dir_tab[k].tick, dir_tab[k].typed, dir_tab[k].want);
        run_ticks(200);
        drain();

        // Conversion on, sender idling heavily; pause once mid-transaction
        bcd_reg(1'b1, 1'b1);
        send_idle_pct = 52;
        recv_idle_pct = 19;
        run_ticks(80);
        start_mid();
        drain();
        run_ticks(100);
        drain();

        // Conversion off, no idling; hold off the receiver to back up the block
        bcd_reg(1'b1, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_token++;
        run_ticks(100);
        drain();

        // Conversion back on at full rate
        bcd_reg(1'b1, 1'b1);
        run_ticks(100);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pin_queue.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pin_queue.size());
        end
        $display("Sent %0d ticks: %0d writes and %0d reads done, %0d reads converted.",
                 ticks_total, writes_done, reads_done, bcd_reads);
        $display("Checked %0d pin results, %0d mismatches.", checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
